/* rtl/gsha_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// gsha_pkg
// Shared types and constants of the generational slot handle allocator.
// ----------------------------------------------------------------------------
package gsha_pkg;

  // Bits of a handle that carry the slot index.
  localparam int INDEX_W = 14;

  // Amount added to a slot's id on every allocate.
  localparam logic [31:0] ID_STEP = 32'h0000_4000;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_BAD_INDEX = 3'd2,
    ST_SLOT_FREE = 3'd3,
    ST_STALE     = 3'd4
  } status_t;

  typedef enum logic [0:0] {
    OP_ALLOC   = 1'b0,
    OP_RELEASE = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_A_POP,
    S_A_ADDR,
    S_A_WR,
    S_SCAN,
    S_R_CHK,
    S_RESP
  } seq_state_t;

  // Commands to the free-slot queue.
  typedef struct packed {
    logic push;
    logic pop;
  } q_ctrl_t;

  // Fill level flags of the free-slot queue.
  typedef struct packed {
    logic empty;
    logic full;
    logic last_free;
  } q_stat_t;

endpackage : gsha_pkg
`default_nettype wire

/* rtl/gsha_req_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// gsha_req_if
// Request channel: one allocate or release word per handshake.
// ----------------------------------------------------------------------------
interface gsha_req_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [31:0] entity_ref;
  logic [31:0] handle;

  modport source (output valid, output op, output entity_ref, output handle, input ready);
  modport sink   (input valid, input op, input entity_ref, input handle, output ready);
endinterface : gsha_req_if
`default_nettype wire

/* rtl/gsha_rsp_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// gsha_rsp_if
// Response channel: status and new handle, one word per request.
// ----------------------------------------------------------------------------
interface gsha_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [31:0] handle_out;

  modport source (output valid, output status, output handle_out, input ready);
  modport sink   (input valid, input status, input handle_out, output ready);
endinterface : gsha_rsp_if
`default_nettype wire

/* rtl/gsha_free_queue.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// gsha_free_queue
// Circular queue of free slot indices held in a small synchronous memory.
// ----------------------------------------------------------------------------
module gsha_free_queue
  import gsha_pkg::*;
#(
  parameter int QUEUE_DEPTH = 32,
  parameter int SLOT_W      = 13
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire q_ctrl_t           ctrl,
  input  wire logic [SLOT_W-1:0] push_data,
  output      logic [SLOT_W-1:0] head_data,
  output      q_stat_t           stat
);

  localparam int QW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic [SLOT_W-1:0] qmem [QUEUE_DEPTH];
  logic [QW-1:0]     head;
  logic [QW-1:0]     tail;
  logic [CW-1:0]     count;

  function automatic logic [QW-1:0] ptr_inc(input logic [QW-1:0] p);
    ptr_inc = (p == QW'(QUEUE_DEPTH - 1)) ? '0 : p + QW'(1);
  endfunction

  // The head entry is read every cycle through a register; it is valid in the cycle after head moves.
  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      qmem[tail] <= push_data;
    end
    head_data <= qmem[head];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (ctrl.push) begin
        tail <= ptr_inc(tail);
      end
      if (ctrl.pop) begin
        head <= ptr_inc(head);
      end
      if (ctrl.push && !ctrl.pop) begin
        count <= count + CW'(1);
      end else if (ctrl.pop && !ctrl.push) begin
        count <= count - CW'(1);
      end
    end
  end

  always_comb begin
    stat.empty     = (count == '0);
    stat.full      = (count == CW'(QUEUE_DEPTH));
    stat.last_free = (count == CW'(QUEUE_DEPTH - 1));
  end

endmodule : gsha_free_queue
`default_nettype wire

/* rtl/generational_slot_handle_allocator_top.sv */
`default_nettype none
// An allocate is accepted in S_IDLE and passes S_A_ADDR, S_A_WR and S_RESP before the response
// word is registered; a release passes S_R_CHK and S_RESP. No new request is taken until the
// response register has taken the result. An allocate that finds the queue empty first runs a
// refill scan, one slot per cycle, then passes S_A_POP to reload the queue head once it has
// found a slot. After reset a clearing pass over every slot initialises the slot table and
// free-slot queue; no request is taken before.
// ----------------------------------------------------------------------------
// generational_slot_handle_allocator_top
// Hands out generational handles over a fixed slot table and checks releases.
// ----------------------------------------------------------------------------
module generational_slot_handle_allocator_top
  import gsha_pkg::*;
#(
  parameter int NUM_SLOTS   = 8192,
  parameter int QUEUE_DEPTH = 32
) (
  input  wire logic   clk,
  input  wire logic   rst,
  gsha_req_if.sink    req,
  gsha_rsp_if.source  rsp
);

  // Slot address width, and the number of slots the queue holds after reset.
  localparam int AW    = $clog2(NUM_SLOTS);
  localparam int QINIT = (QUEUE_DEPTH < NUM_SLOTS) ? QUEUE_DEPTH : NUM_SLOTS;

  localparam logic [INDEX_W:0] SLOT_LIMIT = (INDEX_W + 1)'(NUM_SLOTS);
  localparam logic [AW-1:0]    LAST_SLOT  = AW'(NUM_SLOTS - 1);

  // The slot table: each entry holds {id, owner}. An owner of zero means free.
  logic [63:0]   slot_mem [NUM_SLOTS];
  logic [63:0]   mem_rdata;
  logic [63:0]   mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [AW-1:0] mem_waddr;
  logic          mem_we;
  logic [31:0]   mem_id;
  logic [31:0]   mem_owner;

  // Sequencer state.
  seq_state_t    state;
  seq_state_t    state_next;
  logic [AW-1:0] clr_addr;

  // The accepted request word.
  logic          op_reg;
  logic [31:0]   ref_reg;
  logic [31:0]   handle_reg;
  logic [AW-1:0] slot_reg;

  // Refill scan: scan_addr is the next slot to read, scan_rd_addr the slot whose
  // data arrives this cycle, and visited counts the slots already inspected.
  logic [AW-1:0] scan_cursor;
  logic [AW-1:0] scan_addr;
  logic [AW-1:0] scan_rd_addr;
  logic          scan_rd_valid;
  logic [AW-1:0] visited;
  logic          scan_free;
  logic          scan_done;
  logic          scan_none;

  // Release checks.
  logic [INDEX_W-1:0] rel_idx;
  logic               rel_bad;
  logic               rel_ok;
  status_t            rel_status;

  // Result held until the response register is free, and the response register.
  status_t       res_status;
  logic [31:0]   res_handle;
  logic          out_valid;
  status_t       out_status;
  logic [31:0]   out_handle;
  logic          out_free;

  // Free-slot queue.
  q_ctrl_t       q_ctrl;
  q_stat_t       q_stat;
  logic [AW-1:0] q_push_data;
  logic [AW-1:0] q_head_data;

  function automatic logic [AW-1:0] slot_inc(input logic [AW-1:0] s);
    slot_inc = (s == LAST_SLOT) ? '0 : s + AW'(1);
  endfunction

  gsha_free_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .SLOT_W      (AW)
  ) u_free_queue (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (q_ctrl),
    .push_data (q_push_data),
    .head_data (q_head_data),
    .stat      (q_stat)
  );

  // Single-port-write, single-read slot table with a registered read.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      slot_mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata <= slot_mem[mem_raddr];
  end

  assign mem_id    = mem_rdata[63:32];
  assign mem_owner = mem_rdata[31:0];

  // A scanned slot is pushed when it is free; the scan stops once the queue
  // fills or once every slot has been inspected.
  assign scan_free = scan_rd_valid && (mem_owner == '0);
  assign scan_done = scan_rd_valid && ((scan_free && q_stat.last_free) || (visited == LAST_SLOT));
  assign scan_none = q_stat.empty && !scan_free;

  // Release checks in order: index range, occupancy, exact id match.
  assign rel_idx = handle_reg[INDEX_W-1:0];
  assign rel_bad = ({1'b0, rel_idx} >= SLOT_LIMIT);

  always_comb begin
    if (rel_bad) begin
      rel_status = ST_BAD_INDEX;
    end else if (mem_owner == '0) begin
      rel_status = ST_SLOT_FREE;
    end else if (mem_id != handle_reg) begin
      rel_status = ST_STALE;
    end else begin
      rel_status = ST_OK;
    end
  end

  assign rel_ok   = (rel_status == ST_OK);
  assign out_free = !out_valid || rsp.ready;

  // Next-state logic.
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (clr_addr == LAST_SLOT) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req.valid) begin
          state_next = (req.op == OP_RELEASE) ? S_R_CHK : S_A_ADDR;
        end
      end
      S_A_POP: state_next = S_A_ADDR;
      S_A_ADDR: begin
        state_next = q_stat.empty ? S_SCAN : S_A_WR;
      end
      S_SCAN: begin
        if (scan_done) begin
          state_next = scan_none ? S_RESP : S_A_POP;
        end
      end
      S_A_WR:  state_next = S_RESP;
      S_R_CHK: state_next = S_RESP;
      S_RESP: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

  // Output and datapath control decode.
  always_comb begin
    req.ready   = 1'b0;
    mem_raddr   = '0;
    mem_we      = 1'b0;
    mem_waddr   = '0;
    mem_wdata   = '0;
    q_ctrl      = '0;
    q_push_data = '0;
    case (state)
      S_CLEAR: begin
        // Slot i starts with id i and no owner; the first slots go into the queue.
        mem_we      = 1'b1;
        mem_waddr   = clr_addr;
        mem_wdata   = {32'(clr_addr), 32'd0};
        q_ctrl.push = ({1'b0, clr_addr} < (AW + 1)'(QINIT));
        q_push_data = clr_addr;
      end
      S_IDLE: begin
        req.ready = 1'b1;
        mem_raddr = req.handle[AW-1:0];
      end
      S_A_ADDR: begin
        mem_raddr  = q_head_data;
        q_ctrl.pop = !q_stat.empty;
      end
      S_SCAN: begin
        mem_raddr   = scan_addr;
        q_ctrl.push = scan_free;
        q_push_data = scan_rd_addr;
      end
      S_A_WR: begin
        mem_we    = 1'b1;
        mem_waddr = slot_reg;
        mem_wdata = {mem_id + ID_STEP, ref_reg};
      end
      S_R_CHK: begin
        // A freed slot keeps its id; it is queued only if there is room.
        mem_we      = rel_ok;
        mem_waddr   = handle_reg[AW-1:0];
        mem_wdata   = {mem_id, 32'd0};
        q_ctrl.push = rel_ok && !q_stat.full;
        q_push_data = handle_reg[AW-1:0];
      end
      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      clr_addr      <= '0;
      scan_cursor   <= '0;
      scan_rd_valid <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + AW'(1);
      end
      if (state == S_A_ADDR) begin
        scan_rd_valid <= 1'b0;
      end else if (state == S_SCAN) begin
        scan_rd_valid <= 1'b1;
        if (scan_done) begin
          scan_cursor <= slot_inc(scan_rd_addr);
        end
      end
      if (state == S_RESP && out_free) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (state == S_IDLE && req.valid) begin
      op_reg     <= req.op;
      ref_reg    <= req.entity_ref;
      handle_reg <= req.handle;
    end
    case (state)
      S_A_ADDR: begin
        slot_reg  <= q_head_data;
        scan_addr <= scan_cursor;
        visited   <= '0;
      end
      S_SCAN: begin
        scan_addr    <= slot_inc(scan_addr);
        scan_rd_addr <= scan_addr;
        if (scan_rd_valid) begin
          visited <= visited + AW'(1);
        end
        // Only used when the scan finds nothing: the table is full.
        res_status <= ST_FULL;
        res_handle <= '0;
      end
      S_A_WR: begin
        res_status <= ST_OK;
        res_handle <= mem_id + ID_STEP;
      end
      S_R_CHK: begin
        res_status <= rel_status;
        res_handle <= '0;
      end
      S_RESP: begin
        if (out_free) begin
          out_status <= res_status;
          out_handle <= res_handle;
        end
      end
      default: begin
      end
    endcase
  end

  assign rsp.valid      = out_valid;
  assign rsp.status     = out_status;
  assign rsp.handle_out = out_handle;

`ifndef SYNTHESIS
  // The queue never takes a slot when full nor gives one when empty.
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    !(q_ctrl.push && q_stat.full))
    else $error("free queue pushed while full");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    !(q_ctrl.pop && q_stat.empty))
    else $error("free queue popped while empty");

  // No request is taken while the clearing pass still runs.
  a_no_req_in_clear: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> !req.ready)
    else $error("request accepted during clearing pass");

  // A failed response never carries a handle; this check does not include successful releases.
  a_fail_zero_handle: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && (rsp.status != ST_OK)) |-> (rsp.handle_out == '0))
    else $error("failed response carries a handle");

  // An allocate write-back always follows a queue pop.
  a_wr_after_pop: assert property (@(posedge clk) disable iff (rst)
    (state == S_A_WR) |-> $past(q_ctrl.pop) && (op_reg == OP_ALLOC))
    else $error("allocate write-back without a popped slot");
`endif

endmodule : generational_slot_handle_allocator_top
`default_nettype wire
